@@ hw/rtl/pta_pkg.sv @@
`default_nettype none

package pta_pkg;

  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 64;
  localparam int unsigned RootW = 39;
  localparam int unsigned WordNumW = 36;
  localparam int unsigned WideW = 37;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdCheck = 1'b1;

  localparam logic RegRootTableAddr = 1'b0;

  localparam int unsigned BitPresent = 0;
  localparam int unsigned BitWrite = 1;
  localparam int unsigned BitLarge = 7;

  localparam logic [1:0] LevelRoot = 2'd0;
  localparam logic [1:0] LevelGiga = 2'd1;
  localparam logic [1:0] LevelMega = 2'd2;
  localparam logic [1:0] LevelLeaf = 2'd3;

  typedef enum logic {
    WalkIdle,
    WalkBusy
  } walk_state_e;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  function automatic logic [8:0] va_slice(input logic [47:0] va, input logic [1:0] level);
    logic [8:0] s;
    unique case (level)
      LevelRoot: s = va[47:39];
      LevelGiga: s = va[38:30];
      LevelMega: s = va[29:21];
      default:   s = va[20:12];
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pta_mem.sv @@
`default_nettype none

module pta_mem #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic               clk_i,
  input  pta_pkg::mem_ctl_t  ctl_i,
  input  logic [AddrW-1:0]   waddr_i,
  input  logic [63:0]        wdata_i,
  input  logic [AddrW-1:0]   raddr_i,
  output logic [63:0]        rdata_o
);

  logic [63:0] mem_q [Depth];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/pta_cfg.sv @@
`default_nettype none

module pta_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pta_pkg::PaddrW-1:0]    paddr,
  input  logic [pta_pkg::PdataW-1:0]    pwdata,
  output logic [pta_pkg::PdataW-1:0]    prdata,
  output logic                          pready,
  output logic [pta_pkg::RootW-1:0]     root_o
);

  logic [pta_pkg::RootW-1:0] root_q;
  logic [pta_pkg::RootW-1:0] root_d;
  logic                      reg_sel;
  logic                      wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    root_d = root_q;
    if (wr_en && (reg_sel == pta_pkg::RegRootTableAddr)) begin
      root_d = pwdata[pta_pkg::RootW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else begin
      root_q <= root_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == pta_pkg::RegRootTableAddr) begin
      prdata = {{(pta_pkg::PdataW - pta_pkg::RootW){1'b0}}, root_q};
    end
  end

  assign root_o = root_q;

endmodule

`default_nettype wire

@@ hw/rtl/pta_walk.sv @@
`default_nettype none

module pta_walk #(
  parameter int unsigned StoreWords = 4096,
  parameter int unsigned AddrW = $clog2(StoreWords)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [pta_pkg::RootW-1:0]  root_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       command_i,
  input  logic [11:0]                word_index_i,
  input  logic [63:0]                word_data_i,
  input  logic [47:0]                virtual_address_i,
  input  logic                       write_check_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       allowed_o,
  output logic [1:0]                 mapping_size_o,
  output logic [2:0]                 fault_level_o,
  output pta_pkg::mem_ctl_t          mem_ctl_o,
  output logic [AddrW-1:0]           mem_waddr_o,
  output logic [63:0]                mem_wdata_o,
  output logic [AddrW-1:0]           mem_raddr_o,
  input  logic [63:0]                mem_rdata_i
);

  localparam logic [pta_pkg::WideW-1:0] WordLimit = pta_pkg::WideW'(StoreWords);

  pta_pkg::walk_state_e state_q, state_d;
  logic [1:0]  level_q, level_d;
  logic        inrange_q, inrange_d;
  logic [47:0] va_q;
  logic        wr_q;
  logic        out_valid_q;
  logic        allowed_q;
  logic [1:0]  size_q;
  logic [2:0]  flevel_q;

  logic                          acc;
  logic [pta_pkg::WideW-1:0]     widx_wide;
  logic                          widx_ok;
  logic [pta_pkg::WordNumW-1:0]  root_word;
  logic                          root_ok;
  logic [pta_pkg::WordNumW-1:0]  next_word;
  logic                          next_ok;
  logic                          fault;
  logic                          final_entry;
  logic                          perm_fault;
  logic                          done;
  logic                          can_finish;
  logic                          res_allowed;
  logic [1:0]                    res_size;
  logic [2:0]                    res_flevel;

  assign acc       = in_valid_i && in_ready_o;
  assign widx_wide = {{(pta_pkg::WideW - 12){1'b0}}, word_index_i};
  assign widx_ok   = widx_wide < WordLimit;
  assign root_word = {root_i[38:12], pta_pkg::va_slice(virtual_address_i, pta_pkg::LevelRoot)};
  assign root_ok   = {1'b0, root_word} < WordLimit;
  assign next_word = {mem_rdata_i[38:12], pta_pkg::va_slice(va_q, level_q + 2'd1)};
  assign next_ok   = {1'b0, next_word} < WordLimit;

  assign fault       = !inrange_q || !mem_rdata_i[pta_pkg::BitPresent];
  assign final_entry = (level_q == pta_pkg::LevelLeaf) ||
                       (((level_q == pta_pkg::LevelGiga) || (level_q == pta_pkg::LevelMega)) &&
                        mem_rdata_i[pta_pkg::BitLarge]);
  assign perm_fault  = final_entry && wr_q && !mem_rdata_i[pta_pkg::BitWrite];
  assign done        = fault || final_entry;
  assign can_finish  = !out_valid_q || out_ready_i;
  assign res_allowed = !fault && !perm_fault;
  assign res_size    = res_allowed ? 2'(3'd4 - {1'b0, level_q}) : 2'd0;
  assign res_flevel  = res_allowed ? 3'd0 : ({1'b0, level_q} + 3'd1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pta_pkg::WalkIdle: begin
        if (acc && (command_i == pta_pkg::CmdCheck)) begin
          state_d = pta_pkg::WalkBusy;
        end
      end
      pta_pkg::WalkBusy: begin
        if (done && can_finish) begin
          state_d = pta_pkg::WalkIdle;
        end
      end
      default: state_d = pta_pkg::WalkIdle;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    mem_ctl_o.we = 1'b0;
    mem_ctl_o.re = 1'b0;
    mem_raddr_o  = root_word[AddrW-1:0];
    level_d      = level_q;
    inrange_d    = inrange_q;
    unique case (state_q)
      pta_pkg::WalkIdle: begin
        in_ready_o   = 1'b1;
        mem_ctl_o.we = acc && (command_i == pta_pkg::CmdWrite) && widx_ok;
        if (acc && (command_i == pta_pkg::CmdCheck)) begin
          mem_ctl_o.re = root_ok;
          level_d      = pta_pkg::LevelRoot;
          inrange_d    = root_ok;
        end
      end
      pta_pkg::WalkBusy: begin
        mem_raddr_o = next_word[AddrW-1:0];
        if (!done) begin
          mem_ctl_o.re = next_ok;
          level_d      = level_q + 2'd1;
          inrange_d    = next_ok;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  assign mem_waddr_o = widx_wide[AddrW-1:0];
  assign mem_wdata_o = word_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pta_pkg::WalkIdle;
      level_q     <= pta_pkg::LevelRoot;
      inrange_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      level_q   <= level_d;
      inrange_q <= inrange_d;
      if ((state_q == pta_pkg::WalkBusy) && done && can_finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      va_q <= virtual_address_i;
      wr_q <= write_check_i;
    end
    if ((state_q == pta_pkg::WalkBusy) && done && can_finish) begin
      allowed_q <= res_allowed;
      size_q    <= res_size;
      flevel_q  <= res_flevel;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign allowed_o      = allowed_q;
  assign mapping_size_o = size_q;
  assign fault_level_o  = flevel_q;

`ifndef SYNTH
  a_we_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl_o.we |-> (state_q == pta_pkg::WalkIdle))
    else $error("table write outside idle");

  a_no_we_re: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctl_o.we && mem_ctl_o.re))
    else $error("table write and read in one cycle");

  a_result_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == pta_pkg::WalkBusy))
    else $error("result without a walk");

  a_success_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && allowed_q) |-> ((flevel_q == 3'd0) && (size_q != 2'd0)))
    else $error("inconsistent success result");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/page_table_access_checker.sv @@
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_ready_o  command, word_index, word_data,
//                                            virtual_address, write_check
// out      output     out_valid_o/out_ready_i allowed, mapping_size, fault_level
// config   input      psel/penable/pwrite    paddr, pwdata, prdata (pready high)
//
// A write transfer stores its word in the table memory if its word index is below STORE_WORDS.
// A check transfer issues the root-entry read in its accept cycle and then reads one table entry
// per level visited, through the read port of the table memory, until a fault or a final entry.
// Reset clears the control state and the root register; the table memory is not cleared.
// A finished result waits in the output register; a new transfer is taken meanwhile,
// and a second walk holds its last level until the output register is free.
`default_nettype none

module page_table_access_checker #(
  parameter int unsigned STORE_WORDS = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pta_pkg::PaddrW-1:0]  paddr,
  input  logic [pta_pkg::PdataW-1:0]  pwdata,
  output logic [pta_pkg::PdataW-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic [11:0]                 word_index_i,
  input  logic [63:0]                 word_data_i,
  input  logic [47:0]                 virtual_address_i,
  input  logic                        write_check_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        allowed_o,
  output logic [1:0]                  mapping_size_o,
  output logic [2:0]                  fault_level_o
);

  localparam int unsigned AddrW = $clog2(STORE_WORDS);

  logic [pta_pkg::RootW-1:0] root;
  pta_pkg::mem_ctl_t         mem_ctl;
  logic [AddrW-1:0]          mem_waddr;
  logic [63:0]               mem_wdata;
  logic [AddrW-1:0]          mem_raddr;
  logic [63:0]               mem_rdata;

  pta_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .root_o  (root)
  );

  pta_walk #(
    .StoreWords (STORE_WORDS),
    .AddrW      (AddrW)
  ) u_walk (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .root_i            (root),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .word_index_i      (word_index_i),
    .word_data_i       (word_data_i),
    .virtual_address_i (virtual_address_i),
    .write_check_i     (write_check_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .allowed_o         (allowed_o),
    .mapping_size_o    (mapping_size_o),
    .fault_level_o     (fault_level_o),
    .mem_ctl_o         (mem_ctl),
    .mem_waddr_o       (mem_waddr),
    .mem_wdata_o       (mem_wdata),
    .mem_raddr_o       (mem_raddr),
    .mem_rdata_i       (mem_rdata)
  );

  pta_mem #(
    .Depth (STORE_WORDS),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire
